FILE: hw/rtl/lfw_pkg.sv
// ============================================================================
// lfw_pkg - shared definitions for the linear tail fade
// Field widths, register indexes, reset values and the records that travel
// between the front pipeline and the quotient pipeline.
// ============================================================================
package lfw_pkg;

  localparam int SAMPLE_W = 8;
  localparam int GAIN_W   = 9;
  localparam int FIELD_W  = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;
  // The scaled deviation never reaches 256, so eight quotient bits suffice
  // once an overflow check has ruled out larger quotients.
  localparam int QUO_W    = 8;

  localparam int DEF_GAIN_FRAC_BITS = 8;
  localparam int DEF_LENGTH_BITS    = 16;

  localparam logic [SAMPLE_W-1:0] MID       = 8'd128;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 8'd255;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 8'd0;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END_GAIN   = 2'd2;

  localparam logic [CFG_W-1:0]  RST_WINDOW     = 16'd1024;
  localparam logic [GAIN_W-1:0] RST_START_GAIN = 9'd256;
  localparam logic [GAIN_W-1:0] RST_END_GAIN   = 9'd0;

  // Per-word information that rides along with the arithmetic.
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                neg;
    logic                pass;
  } side_t;

  // Outcome of the quotient pipeline.
  typedef struct packed {
    logic [QUO_W-1:0] quo;
    logic             ovf;
    logic             rem_nz;
    side_t            side;
  } div_res_t;

endpackage

FILE: hw/rtl/lfw_div.sv
// ============================================================================
// lfw_div - pipelined restoring divider
// An overflow stage followed by one quotient bit per stage, with a valid
// bit per stage and a ready chain that lets bubbles close up.
// ============================================================================
module lfw_div #(
  parameter int NUM_W = 34,
  parameter int DEN_W = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [NUM_W-1:0]     in_num,
  input  logic [DEN_W-1:0]     in_den,
  input  lfw_pkg::side_t       in_side,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lfw_pkg::div_res_t    out_res
);

  localparam int QB    = lfw_pkg::QUO_W;
  localparam int WIDE  = (NUM_W > DEN_W + QB) ? NUM_W : DEN_W + QB;
  localparam int EXT_W = WIDE + 1;

  logic [EXT_W-1:0]     rem_r  [QB+1];
  logic [EXT_W-1:0]     den_r  [QB+1];
  logic [QB-1:0]        quo_r  [QB+1];
  logic                 ovf_r  [QB+1];
  lfw_pkg::side_t       side_r [QB+1];
  logic [QB:0]          vld_r;
  logic [QB+1:0]        en;

  logic [EXT_W-1:0]     num_x;
  logic [EXT_W-1:0]     den_x;

  assign num_x = EXT_W'(in_num);
  assign den_x = EXT_W'(in_den);

  assign en[QB+1] = out_ready;

  genvar j;
  generate
    for (j = 0; j <= QB; j++) begin : g_en
      assign en[j] = !vld_r[j] || en[j+1];
    end
  endgenerate

  // Stage 0: decide whether the quotient would need more than QB bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en[0]) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem_r[0]  <= num_x;
      den_r[0]  <= den_x;
      quo_r[0]  <= '0;
      ovf_r[0]  <= (num_x >= (den_x << QB));
      side_r[0] <= in_side;
    end
  end

  // Stage j settles quotient bit QB-j.
  generate
    for (j = 1; j <= QB; j++) begin : g_stage
      localparam int B = QB - j;
      logic [EXT_W-1:0] trial;
      logic             take;

      assign trial = den_r[j-1] << B;
      assign take  = !ovf_r[j-1] && (rem_r[j-1] >= trial);

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[j] <= 1'b0;
        end else if (en[j]) begin
          vld_r[j] <= vld_r[j-1];
        end
      end

      always_ff @(posedge clk) begin
        if (en[j]) begin
          rem_r[j]  <= take ? (rem_r[j-1] - trial) : rem_r[j-1];
          den_r[j]  <= den_r[j-1];
          quo_r[j]  <= quo_r[j-1] | (take ? (QB'(1) << B) : '0);
          ovf_r[j]  <= ovf_r[j-1];
          side_r[j] <= side_r[j-1];
        end
      end
    end
  endgenerate

  assign in_ready       = en[0];
  assign out_valid      = vld_r[QB];
  assign out_res.quo    = quo_r[QB];
  assign out_res.ovf    = ovf_r[QB];
  assign out_res.rem_nz = (rem_r[QB] != '0);
  assign out_res.side   = side_r[QB];

  // Without overflow the restoring steps must leave a remainder below the divisor.
  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[QB] && !ovf_r[QB] |-> rem_r[QB] < den_r[QB])
    else $error("divider remainder not below divisor");

  // A stalled result keeps its valid and its quotient.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(quo_r[QB]))
    else $error("divider result changed while stalled");

endmodule

FILE: hw/rtl/linear_fade_tail_of_word.sv
// ============================================================================
// linear_fade_tail_of_word - linear gain ramp over the tail of a word
// Scales the deviation of each offset-binary sample from silence by a gain
// that runs from the start gain to the end gain over the last samples of
// the word, rounding the signed result down and saturating to the 8-bit range.
// ============================================================================
// An accepted input word passes through three front stages, nine divider
// stages and one output register before its result word appears.
// Throughput: one word per cycle unless a held result fills the pipeline; the
// bit-per-stage divider sets the depth; per-stage valid bits close bubbles.
// Reset (rst_n low at a clock edge, synchronous) empties the pipeline and
// loads window 1024, start gain 256 and end gain 0.
module linear_fade_tail_of_word #(
  parameter int GAIN_FRAC_BITS = lfw_pkg::DEF_GAIN_FRAC_BITS,
  parameter int LENGTH_BITS    = lfw_pkg::DEF_LENGTH_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input words.
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // Fields from bit 0 up: sample_value[7:0], sample_index[23:8],
  // word_length[39:24].
  input  logic [39:0]                    in_tdata,
  // Result words.
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // Fields from bit 0 up: shaped_sample[7:0].
  output logic [7:0]                     out_tdata,
  // Fields from bit 0 up: clipped[0].
  output logic [0:0]                     out_tuser,
  // Configuration writes.
  input  logic                           cfg_we,
  input  logic [lfw_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [lfw_pkg::CFG_W-1:0]      cfg_wdata
);

  // Internal widths. The gain sum holds end*(w-rem) + start*rem, the
  // product holds the sample deviation times that sum, and the divisor is
  // the window length carrying the gain fraction bits.
  localparam int LEN_W = LENGTH_BITS;
  localparam int GW    = LEN_W + lfw_pkg::GAIN_W + 1;
  localparam int NUM_W = GW + lfw_pkg::SAMPLE_W;
  localparam int DEN_W = LEN_W + GAIN_FRAC_BITS;

  // ---------------------------------------------------------------------------
  // Configuration registers. The user must write only while the datapath is
  // idle; the block does not enforce it and reads them without shadow copies.
  // ---------------------------------------------------------------------------
  logic [lfw_pkg::CFG_W-1:0]  window_r;
  logic [lfw_pkg::GAIN_W-1:0] start_gain_r;
  logic [lfw_pkg::GAIN_W-1:0] end_gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r     <= lfw_pkg::RST_WINDOW;
      start_gain_r <= lfw_pkg::RST_START_GAIN;
      end_gain_r   <= lfw_pkg::RST_END_GAIN;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        lfw_pkg::REG_WINDOW:     window_r     <= cfg_wdata;
        lfw_pkg::REG_START_GAIN: start_gain_r <= cfg_wdata[lfw_pkg::GAIN_W-1:0];
        lfw_pkg::REG_END_GAIN:   end_gain_r   <= cfg_wdata[lfw_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Ready chain. Each stage loads when it is empty or when the stage after it
  // is moving, so a held result stalls upstream words only behind full stages.
  // ---------------------------------------------------------------------------
  logic s1_vld_r, s2_vld_r, s3_vld_r, out_vld_r;
  logic en1, en2, en3, en_o;
  logic div_in_ready;
  logic div_out_valid;
  lfw_pkg::div_res_t div_res;

  assign en_o = !out_vld_r || out_tready;
  assign en3  = !s3_vld_r || div_in_ready;
  assign en2  = !s2_vld_r || en3;
  assign en1  = !s1_vld_r || en2;
  assign in_tready = en1;

  // ---------------------------------------------------------------------------
  // Stage 1: unpack, find the effective window, the distance to the word end
  // and whether the sample lies outside the ramp. A window of zero acts as a
  // window of one. Samples at or past the word end, or before the window,
  // pass unchanged.
  // ---------------------------------------------------------------------------
  logic [lfw_pkg::SAMPLE_W-1:0] in_sample;
  logic [LEN_W-1:0]             in_idx;
  logic [LEN_W-1:0]             in_len;
  logic [LEN_W-1:0]             win_raw;
  logic [LEN_W-1:0]             win_eff;
  logic [LEN_W-1:0]             w_c;
  logic [LEN_W-1:0]             rem_c;
  logic                         pass_c;
  logic                         neg_c;
  logic [lfw_pkg::SAMPLE_W-1:0] dev_c;

  always_comb begin
    in_sample = in_tdata[7:0];
    in_idx    = LEN_W'(in_tdata[23:8]);
    in_len    = LEN_W'(in_tdata[39:24]);
    win_raw   = LEN_W'(window_r);
    win_eff   = (win_raw == '0) ? LEN_W'(1) : win_raw;
    w_c       = (win_eff < in_len) ? win_eff : in_len;
    rem_c     = in_len - in_idx;
    pass_c    = (in_idx >= in_len) || (rem_c > w_c);
    neg_c     = (in_sample < lfw_pkg::MID);
    dev_c     = neg_c ? (lfw_pkg::MID - in_sample) : (in_sample - lfw_pkg::MID);
  end

  lfw_pkg::side_t               s1_side_r;
  logic [lfw_pkg::SAMPLE_W-1:0] s1_dev_r;
  logic [LEN_W-1:0]             s1_w_r;
  logic [LEN_W-1:0]             s1_rem_r;
  logic [LEN_W-1:0]             s1_wmr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en1) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_side_r.sample <= in_sample;
      s1_side_r.neg    <= neg_c;
      s1_side_r.pass   <= pass_c;
      s1_dev_r         <= dev_c;
      s1_w_r           <= w_c;
      s1_rem_r         <= rem_c;
      s1_wmr_r         <= w_c - rem_c;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: the ramp numerator end*(w-rem) + start*rem, and the divisor
  // w scaled by the gain fraction. For pass-through words these are junk and
  // ignored at the output.
  // ---------------------------------------------------------------------------
  lfw_pkg::side_t               s2_side_r;
  logic [lfw_pkg::SAMPLE_W-1:0] s2_dev_r;
  logic [GW-1:0]                s2_g_r;
  logic [DEN_W-1:0]             s2_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en2) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_side_r <= s1_side_r;
      s2_dev_r  <= s1_dev_r;
      s2_g_r    <= (GW'(end_gain_r) * GW'(s1_wmr_r)) + (GW'(start_gain_r) * GW'(s1_rem_r));
      s2_q_r    <= DEN_W'(s1_w_r) << GAIN_FRAC_BITS;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: deviation times ramp numerator, the dividend for the divider.
  // ---------------------------------------------------------------------------
  lfw_pkg::side_t   s3_side_r;
  logic [NUM_W-1:0] s3_p_r;
  logic [DEN_W-1:0] s3_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (en3) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_side_r <= s2_side_r;
      s3_p_r    <= NUM_W'(s2_dev_r) * NUM_W'(s2_g_r);
      s3_q_r    <= s2_q_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Divider: floor quotient, remainder-nonzero flag for rounding the negative
  // half away from silence, and an overflow flag for quotients of 256 or more.
  // ---------------------------------------------------------------------------
  lfw_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s3_vld_r),
    .in_ready  (div_in_ready),
    .in_num    (s3_p_r),
    .in_den    (s3_q_r),
    .in_side   (s3_side_r),
    .out_valid (div_out_valid),
    .out_ready (en_o),
    .out_res   (div_res)
  );

  // ---------------------------------------------------------------------------
  // Output stage: rebuild the offset-binary sample and saturate. Above
  // silence the magnitude is the floor quotient; below silence it is the
  // ceiling, so both halves round the signed deviation down. Landing exactly on zero
  // is not a clip.
  // ---------------------------------------------------------------------------
  logic [lfw_pkg::SAMPLE_W:0]   mag_up;
  logic [lfw_pkg::SAMPLE_W-1:0] shaped_nxt;
  logic                         clip_nxt;

  always_comb begin
    mag_up = {1'b0, div_res.quo} + (lfw_pkg::SAMPLE_W + 1)'(div_res.rem_nz);
    priority if (div_res.side.pass) begin
      shaped_nxt = div_res.side.sample;
      clip_nxt   = 1'b0;
    end else if (!div_res.side.neg) begin
      if (div_res.ovf || (div_res.quo > 8'd127)) begin
        shaped_nxt = lfw_pkg::SAMPLE_MAX;
        clip_nxt   = 1'b1;
      end else begin
        shaped_nxt = lfw_pkg::MID + div_res.quo;
        clip_nxt   = 1'b0;
      end
    end else begin
      if (div_res.ovf || (mag_up > {1'b0, lfw_pkg::MID})) begin
        shaped_nxt = lfw_pkg::SAMPLE_MIN;
        clip_nxt   = 1'b1;
      end else begin
        shaped_nxt = lfw_pkg::MID - mag_up[lfw_pkg::SAMPLE_W-1:0];
        clip_nxt   = 1'b0;
      end
    end
  end

  logic [lfw_pkg::SAMPLE_W-1:0] out_data_r;
  logic                         out_clip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en_o) begin
      out_vld_r <= div_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_o) begin
      out_data_r <= shaped_nxt;
      out_clip_r <= clip_nxt;
    end
  end

  assign out_tvalid   = out_vld_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_clip_r;

  // A clipped result always sits on one of the rails.
  a_clip_on_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_clip_r |->
      (out_data_r == lfw_pkg::SAMPLE_MIN || out_data_r == lfw_pkg::SAMPLE_MAX))
    else $error("clipped result not on a rail");

  // The input side only stalls when the whole pipeline backs up behind a
  // held result.
  a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_vld_r && !out_tready && s1_vld_r && s2_vld_r && s3_vld_r)
    else $error("input stalled without a full pipeline");

endmodule
